FILE: src/stq_pkg.sv
// Shared types and constants for the sorted timer event queue.
// Used by stq_ctrl, stq_datapath, the top level and the checker.
package stq_pkg;

	localparam int QUEUE_SLOTS_DEF  = 16;
	localparam int TASK_ID_BITS_DEF = 8;
	localparam int SEC_W            = 32;
	localparam int USEC_W           = 20;
	localparam int STATUS_W         = 3;
	localparam int OCC_W            = 4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_FULL      = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_SAME_TIME = 3'd2,
		ST_POPPED    = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_HEADCMP,
		S_SHIFT,
		S_PLACE,
		S_POPOUT,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RD_HEAD,
		RD_PREV,
		RD_PREV2
	} rd_sel_t;

	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    eq_cap;
		logic    wr_shift;
		logic    wr_new;
		logic    ptr_back;
		logic    tail_inc;
		logic    head_inc;
		logic    pop_load;
		logic    res_set;
		status_t res_status;
		logic    out_load;
	} stq_cmd_t;

	typedef struct packed {
		logic is_pop;
		logic empty;
		logic full;
		logic later;
		logic prev_is_head;
		logic same_front;
		logic out_free;
	} stq_sts_t;

endpackage

FILE: src/stq_ctrl.sv
// Controller state machine for the sorted timer event queue.
// Depends on stq_pkg; drives stq_datapath through stq_cmd_t.
module stq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  stq_pkg::stq_sts_t sts,
	output stq_pkg::stq_cmd_t cmd
);
	import stq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_pop) begin
					if (sts.empty) begin
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_EMPTY;
						state_d        = S_FINISH;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_HEAD;
						state_d    = S_POPOUT;
					end
				end else if (sts.empty) begin
					cmd.wr_new     = 1'b1;
					cmd.tail_inc   = 1'b1;
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_INSERTED;
					state_d        = S_FINISH;
				end else if (sts.full) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_FULL;
					state_d        = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_HEAD;
					state_d    = S_HEADCMP;
				end
			end
			S_HEADCMP: begin
				// front entry is on the read port; start the walk from the tail
				cmd.eq_cap = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PREV;
				state_d    = S_SHIFT;
			end
			S_SHIFT: begin
				if (sts.later) begin
					cmd.wr_shift = 1'b1;
					cmd.ptr_back = 1'b1;
					if (sts.prev_is_head) begin
						state_d = S_PLACE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_PREV2;
					end
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.wr_new     = 1'b1;
				cmd.tail_inc   = 1'b1;
				cmd.res_set    = 1'b1;
				cmd.res_status = sts.same_front ? ST_SAME_TIME : ST_INSERTED;
				state_d        = S_FINISH;
			end
			S_POPOUT: begin
				cmd.pop_load   = 1'b1;
				cmd.head_inc   = 1'b1;
				cmd.res_set    = 1'b1;
				cmd.res_status = ST_POPPED;
				state_d        = S_FINISH;
			end
			S_FINISH: begin
				// hold the result until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: src/stq_datapath.sv
// Datapath for the sorted timer event queue: event memory, ring indices,
// walk pointer, time compare and output register. Depends on stq_pkg.
module stq_datapath #(
	parameter int QUEUE_SLOTS  = stq_pkg::QUEUE_SLOTS_DEF,
	parameter int TASK_ID_BITS = stq_pkg::TASK_ID_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        operation,
	input  logic [stq_pkg::SEC_W-1:0]   event_sec,
	input  logic [stq_pkg::USEC_W-1:0]  event_usec,
	input  logic [TASK_ID_BITS-1:0]     task_id,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [stq_pkg::STATUS_W-1:0] status,
	output logic [stq_pkg::SEC_W-1:0]   entry_sec,
	output logic [stq_pkg::USEC_W-1:0]  entry_usec,
	output logic [TASK_ID_BITS-1:0]     entry_task,
	output logic [stq_pkg::OCC_W-1:0]   occupancy,
	input  stq_pkg::stq_cmd_t           cmd,
	output stq_pkg::stq_sts_t           sts
);
	import stq_pkg::*;

	localparam int AW      = $clog2(QUEUE_SLOTS);
	localparam int CW      = AW + 1;
	localparam int ENTRY_W = SEC_W + USEC_W + TASK_ID_BITS;
	localparam logic [AW-1:0] LAST = AW'(QUEUE_SLOTS - 1);

	logic [ENTRY_W-1:0] mem [QUEUE_SLOTS];

	logic [AW-1:0]           head_q, tail_q, ptr_q;
	logic                    op_q;
	logic [SEC_W-1:0]        sec_q;
	logic [USEC_W-1:0]       usec_q;
	logic [TASK_ID_BITS-1:0] task_q;
	logic [ENTRY_W-1:0]      rd_data_q;
	logic                    front_eq_q;

	status_t                 res_status_q;
	logic [SEC_W-1:0]        res_sec_q;
	logic [USEC_W-1:0]       res_usec_q;
	logic [TASK_ID_BITS-1:0] res_task_q;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [SEC_W-1:0]        out_sec_q;
	logic [USEC_W-1:0]       out_usec_q;
	logic [TASK_ID_BITS-1:0] out_task_q;
	logic [OCC_W-1:0]        out_occ_q;

	logic [AW-1:0]           ptr_prev, ptr_prev2, tail_next, head_next, rd_addr;
	logic [SEC_W-1:0]        rd_sec;
	logic [USEC_W-1:0]       rd_usec;
	logic [TASK_ID_BITS-1:0] rd_task;
	logic [ENTRY_W-1:0]      wr_data;
	logic [CW-1:0]           count;

	assign ptr_prev  = (ptr_q == '0) ? LAST : ptr_q - AW'(1);
	assign ptr_prev2 = (ptr_prev == '0) ? LAST : ptr_prev - AW'(1);
	assign tail_next = (tail_q == LAST) ? '0 : tail_q + AW'(1);
	assign head_next = (head_q == LAST) ? '0 : head_q + AW'(1);

	assign rd_sec  = rd_data_q[ENTRY_W-1 -: SEC_W];
	assign rd_usec = rd_data_q[TASK_ID_BITS +: USEC_W];
	assign rd_task = rd_data_q[TASK_ID_BITS-1:0];

	always_comb begin
		case (cmd.rd_sel)
			RD_HEAD:  rd_addr = head_q;
			RD_PREV:  rd_addr = ptr_prev;
			RD_PREV2: rd_addr = ptr_prev2;
			default:  rd_addr = head_q;
		endcase
	end

	assign wr_data = cmd.wr_new ? {sec_q, usec_q, task_q} : rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_new || cmd.wr_shift) begin
			mem[ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		sts.is_pop       = (op_q == OP_POP);
		sts.empty        = (head_q == tail_q);
		sts.full         = (tail_next == head_q);
		sts.later        = (rd_sec > sec_q) || ((rd_sec == sec_q) && (rd_usec > usec_q));
		sts.prev_is_head = (ptr_prev == head_q);
		sts.same_front   = (ptr_q == head_q) || front_eq_q;
		sts.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (cmd.tail_inc) begin
				tail_q <= tail_next;
			end
			if (cmd.head_inc) begin
				head_q <= head_next;
			end
		end
	end

	// walk pointer starts at the tail and steps back one slot per shift
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ptr_q <= tail_q;
		end else if (cmd.ptr_back) begin
			ptr_q <= ptr_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= operation;
			sec_q      <= event_sec;
			usec_q     <= event_usec;
			task_q     <= task_id;
			res_sec_q  <= '0;
			res_usec_q <= '0;
			res_task_q <= '0;
		end else if (cmd.pop_load) begin
			res_sec_q  <= rd_sec;
			res_usec_q <= rd_usec;
			res_task_q <= rd_task;
		end
		if (cmd.eq_cap) begin
			front_eq_q <= (rd_sec == sec_q) && (rd_usec == usec_q);
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
		end
	end

	always_comb begin
		if (tail_q >= head_q) begin
			count = {1'b0, tail_q} - {1'b0, head_q};
		end else begin
			count = {1'b0, tail_q} + CW'(QUEUE_SLOTS) - {1'b0, head_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_sec_q    <= res_sec_q;
			out_usec_q   <= res_usec_q;
			out_task_q   <= res_task_q;
			out_occ_q    <= OCC_W'(count);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign entry_sec  = out_sec_q;
	assign entry_usec = out_usec_q;
	assign entry_task = out_task_q;
	assign occupancy  = out_occ_q;

endmodule

FILE: src/sorted_timer_event_queue.sv
// Sorted timer event queue: time-ordered ring of events with insert and pop.
// Instantiates stq_ctrl and stq_datapath; depends on stq_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries operation, event_sec,
//   event_usec and task_id. operation selects insert or pop of the earliest
//   event. Every item gives exactly one result on the output channel
//   (out_valid/out_ready): status, popped entry fields (zero unless popped)
//   and occupancy after the operation.
//   One item is worked on at a time; in_ready is high only when the block
//   is idle, also while an earlier result still sits in the output register.
//   Full/empty answers and empty-queue inserts are settled in S_DECIDE; a
//   pop reads the front and loads it in S_POPOUT; an insert that moves k
//   later entries up one slot (k up to QUEUE_SLOTS-2) compares the front in
//   S_HEADCMP, walks the event memory back from the tail in S_SHIFT, one
//   slot a cycle, and writes the new event in S_PLACE. All end in S_FINISH.
//   At most QUEUE_SLOTS-1 events are held. Reset empties the queue at once
//   (head and tail indices cleared, no memory sweep) and drops any result.
//   When the receiver stalls, the result waits in the output register and
//   the next item's result waits in the controller until it is taken.
module sorted_timer_event_queue #(
	parameter int QUEUE_SLOTS  = stq_pkg::QUEUE_SLOTS_DEF,
	parameter int TASK_ID_BITS = stq_pkg::TASK_ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [stq_pkg::SEC_W-1:0]    event_sec,
	input  logic [stq_pkg::USEC_W-1:0]   event_usec,
	input  logic [TASK_ID_BITS-1:0]      task_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [stq_pkg::STATUS_W-1:0] status,
	output logic [stq_pkg::SEC_W-1:0]    entry_sec,
	output logic [stq_pkg::USEC_W-1:0]   entry_usec,
	output logic [TASK_ID_BITS-1:0]      entry_task,
	output logic [stq_pkg::OCC_W-1:0]    occupancy
);
	import stq_pkg::*;

	stq_cmd_t cmd;
	stq_sts_t sts;

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stq_datapath #(
		.QUEUE_SLOTS  (QUEUE_SLOTS),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (operation),
		.event_sec  (event_sec),
		.event_usec (event_usec),
		.task_id    (task_id),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.entry_sec  (entry_sec),
		.entry_usec (entry_usec),
		.entry_task (entry_task),
		.occupancy  (occupancy),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

FILE: src/stq_checker.sv
// Port-level checks for the sorted timer event queue, bound to the top level.
// Depends on stq_pkg.
module stq_checker #(
	parameter int TASK_ID_BITS = stq_pkg::TASK_ID_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [stq_pkg::STATUS_W-1:0] status,
	input logic [stq_pkg::SEC_W-1:0]    entry_sec,
	input logic [stq_pkg::USEC_W-1:0]   entry_usec,
	input logic [TASK_ID_BITS-1:0]      entry_task,
	input logic [stq_pkg::OCC_W-1:0]    occupancy
);
	import stq_pkg::*;

	// stalled result holds its status and occupancy
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
		else $error("result changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_POPPED |->
			entry_sec == '0 && entry_usec == '0 && entry_task == '0)
		else $error("entry fields nonzero without a pop");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0)
		else $error("empty answer with nonzero occupancy");

endmodule

bind sorted_timer_event_queue stq_checker #(.TASK_ID_BITS(TASK_ID_BITS)) u_stq_checker (.*);
